// File: rtl/core/sqlts_pkg.sv
// Package for the SQL token scanner: token types, scan modes, codes and the keyword table.
package sqlts_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_KEYWORD_CHARS_DEF = 9;

  localparam int RES_MAX = 4;
  localparam int KW_COUNT = 64;
  localparam int KW_CHARS = 9;

  localparam logic [19:0] F20_MAX = 20'hFFFFF;
  localparam logic [15:0] F16_MAX = 16'hFFFF;
  localparam logic [62:0] I63_MAX = {63{1'b1}};

  localparam logic [3:0] KIND_IDENT    = 4'd0;
  localparam logic [3:0] KIND_KEYWORD  = 4'd1;
  localparam logic [3:0] KIND_OPERATOR = 4'd2;
  localparam logic [3:0] KIND_DELIM    = 4'd3;
  localparam logic [3:0] KIND_INT      = 4'd4;
  localparam logic [3:0] KIND_FLOAT    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_END      = 4'd7;
  localparam logic [3:0] KIND_ERROR    = 4'd8;

  localparam logic [5:0] SUB_NONE   = 6'd0;
  localparam logic [5:0] OP_PLUS    = 6'd0;
  localparam logic [5:0] OP_MINUS   = 6'd1;
  localparam logic [5:0] OP_SLASH   = 6'd2;
  localparam logic [5:0] OP_PERCENT = 6'd3;
  localparam logic [5:0] OP_EQ      = 6'd4;
  localparam logic [5:0] OP_NE      = 6'd5;
  localparam logic [5:0] OP_LT      = 6'd6;
  localparam logic [5:0] OP_LE      = 6'd7;
  localparam logic [5:0] OP_GT      = 6'd8;
  localparam logic [5:0] OP_GE      = 6'd9;
  localparam logic [5:0] OP_CONCAT  = 6'd10;

  localparam logic [5:0] DL_LPAREN = 6'd0;
  localparam logic [5:0] DL_RPAREN = 6'd1;
  localparam logic [5:0] DL_COMMA  = 6'd2;
  localparam logic [5:0] DL_SEMI   = 6'd3;
  localparam logic [5:0] DL_DOT    = 6'd4;
  localparam logic [5:0] DL_STAR   = 6'd5;

  localparam logic [5:0] ERR_BYTE     = 6'd0;
  localparam logic [5:0] ERR_BANG     = 6'd1;
  localparam logic [5:0] ERR_PIPE     = 6'd2;
  localparam logic [5:0] ERR_STRING   = 6'd3;
  localparam logic [5:0] ERR_QIDENT   = 6'd4;
  localparam logic [5:0] ERR_OVERFLOW = 6'd5;

  typedef enum logic [4:0] {
    MODE_IDLE, MODE_MINUS, MODE_SLASH, MODE_LCOMMENT, MODE_BLOCK, MODE_BLOCK_STAR,
    MODE_WORD, MODE_INT, MODE_INT_DOT, MODE_FLOAT, MODE_STR, MODE_STR_QUOTE,
    MODE_QID, MODE_LT, MODE_GT, MODE_BANG, MODE_PIPE, MODE_ERROR
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  subtype;
    logic [19:0] offset;
    logic [19:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic [62:0] value;
    logic        last;
  } tok_t;

  typedef logic [8*KW_CHARS-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "SELECT   ", "FROM     ", "WHERE    ", "BETWEEN  ", "DISTINCT ", "LIKE     ",
    "IN       ", "GROUP    ", "BY       ", "ORDER    ", "HAVING   ", "ASC      ",
    "DESC     ", "JOIN     ", "INNER    ", "LEFT     ", "RIGHT    ", "FULL     ",
    "OUTER    ", "CROSS    ", "ON       ", "USING    ", "AND      ", "OR       ",
    "NOT      ", "LIMIT    ", "OFFSET   ", "TOP      ", "FETCH    ", "MIN      ",
    "MAX      ", "COUNT    ", "SUM      ", "AVG      ", "INT      ", "INTEGER  ",
    "BIGINT   ", "FLOAT    ", "DOUBLE   ", "DECIMAL  ", "TEXT     ", "BOOLEAN  ",
    "DATE     ", "TIME     ", "TIMESTAMP", "UNION    ", "INTERSECT", "EXCEPT   ",
    "MINUS    ", "CASE     ", "WHEN     ", "THEN     ", "ELSE     ", "END      ",
    "AS       ", "ALL      ", "ANY      ", "SOME     ", "EXISTS   ", "NULL     ",
    "CAST     ", "IS       ", "TRUE     ", "FALSE    "
  };

  function automatic logic [7:0] kw_byte(input int k, input int i);
    return KW_TEXT[k][8*KW_CHARS-1-8*i -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < KW_CHARS; i++) begin
      if (kw_byte(k, i) != 8'h20) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

endpackage

// File: rtl/core/sql_token_scanner.sv
// Top level of the streaming SQL token scanner.
// The input channel takes at most one source byte and an optional end mark per transaction on
// in_valid / in_ready. Each transaction yields zero to four tokens on the output
// channel out_valid / out_ready, the last of them flagged by last_of_run.
// The scanner state and the token set are computed combinationally from the state
// registers; the tokens land in a four-slot result bank at the same edge as the state.
// The first token of a transaction is presented in the cycle after it is accepted.
// Throughput is one byte per cycle while each byte yields at most one token and out_ready
// is high; a byte that yields several tokens holds the input until its last token is
// taken, since the result bank drains one token per cycle while out_ready is high.
// in_ready is high while the bank is empty or is handing out its last token.
// When the receiver stalls, the tokens wait in the bank and the input stalls.
// Reset clears the scanner to the start of a source and empties the bank.
// An end mark flushes the pending token, emits the end token unless the scanner
// ended in an error, and rearms the scanner for the next source.
module sql_token_scanner
  import sqlts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_byte,
  input  logic [7:0]  char_in,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [5:0]  token_subtype,
  output logic [19:0] start_offset,
  output logic [19:0] token_length,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [62:0] int_value,
  output logic        last_of_run
);

  tok_t [RES_MAX-1:0] toks;
  logic [2:0]         tok_count;
  logic               accept;
  tok_t               out_tok;

  assign accept = in_valid && in_ready;

  sqlts_lexer #(
    .OFFSET_BITS(OFFSET_BITS),
    .POSITION_BITS(POSITION_BITS),
    .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)
  ) u_lexer (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .has_byte(has_byte),
    .char_in(char_in),
    .end_of_source(end_of_source),
    .toks(toks),
    .tok_count(tok_count)
  );

  sqlts_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .load(accept),
    .toks(toks),
    .tok_count(tok_count),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_tok(out_tok),
    .can_load(in_ready)
  );

  assign token_kind = out_tok.kind;
  assign token_subtype = out_tok.subtype;
  assign start_offset = out_tok.offset;
  assign token_length = out_tok.length;
  assign start_line = out_tok.line;
  assign start_column = out_tok.column;
  assign int_value = out_tok.value;
  assign last_of_run = out_tok.last;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result bank not empty after reset");

  a_ready_on_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_of_run)
    else $error("input taken while tokens of the previous byte remain");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> last_of_run && token_length == 20'd0)
    else $error("end token not last or not empty");

  a_value_only_int: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_INT |-> int_value == 63'd0)
    else $error("integer value on a non-integer token");

endmodule

// File: rtl/core/sqlts_lexer.sv
// Scanner state registers and the single-pass next-state and token logic.
module sqlts_lexer
  import sqlts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    has_byte,
  input  logic [7:0]              char_in,
  input  logic                    end_of_source,
  output tok_t [RES_MAX-1:0]      toks,
  output logic [2:0]              tok_count
);

  localparam int OB = OFFSET_BITS;
  localparam int PB = POSITION_BITS;
  localparam int MK = MAX_KEYWORD_CHARS;
  localparam int IW = $clog2(MK);
  localparam int WLW = $clog2(MK + 2);

  typedef logic [7:0] wbuf_t [MK];
  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } kw_hit_t;

  mode_t            scan_mode, scan_mode_next;
  logic [OB-1:0]    byte_position, byte_position_next;
  logic [PB-1:0]    current_line, current_line_next;
  logic [PB-1:0]    current_column, current_column_next;
  logic [OB-1:0]    token_begin, token_begin_next;
  logic [PB-1:0]    token_begin_line, token_begin_line_next;
  logic [PB-1:0]    token_begin_column, token_begin_column_next;
  logic [WLW-1:0]   word_length, word_length_next;
  logic [62:0]      number_accumulator, number_accumulator_next;
  logic             number_overflow, number_overflow_next;
  logic [7:0]       word_buffer [MK];
  logic             wb_we;
  logic [IW-1:0]    wb_idx;
  logic [7:0]       wb_dat;

  function automatic logic [19:0] clamp_off(input logic [OB-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(F20_MAX)) ? F20_MAX : w[19:0];
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [PB-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(F16_MAX)) ? F16_MAX : w[15:0];
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [5:0] sub,
                                  input logic [OB-1:0] len, input logic [62:0] val,
                                  input logic [OB-1:0] b, input logic [PB-1:0] bl,
                                  input logic [PB-1:0] bc);
    tok_t t;
    t.kind = kind;
    t.subtype = sub;
    t.offset = clamp_off(b);
    t.length = clamp_off(len);
    t.line = clamp_pos(bl);
    t.column = clamp_pos(bc);
    t.value = val;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [OB-1:0] span(input logic [OB-1:0] p, input logic [OB-1:0] b);
    return (p >= b) ? p - b : '0;
  endfunction

  function automatic logic [OB-1:0] inc_off(input logic [OB-1:0] p);
    return (p == {OB{1'b1}}) ? p : p + 1'b1;
  endfunction

  function automatic logic [PB-1:0] inc_pos(input logic [PB-1:0] v);
    return (v == {PB{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic kw_hit_t kw_match(input wbuf_t wb, input logic [WLW-1:0] wl);
    kw_hit_t r;
    logic ok;
    r.hit = 1'b0;
    r.idx = 6'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      ok = (wl == WLW'(kw_len(k)));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < int'(kw_len(k)) && wb[i] != kw_byte(k, i)) ok = 1'b0;
      end
      if (ok) begin
        r.hit = 1'b1;
        r.idx = 6'(k);
      end
    end
    return r;
  endfunction

  always_comb begin
    mode_t           m;
    logic [OB-1:0]   p, b, ln_len;
    logic [PB-1:0]   ln, cl, bl, bc;
    logic [WLW-1:0]  wl;
    logic [62:0]     acc;
    logic            ov, fall;
    logic [7:0]      c, u;
    logic [66:0]     prod;
    wbuf_t           wb;
    kw_hit_t         kh;
    tok_t [RES_MAX-1:0] t;
    logic [2:0]      n;

    m = scan_mode;
    p = byte_position;
    ln = current_line;
    cl = current_column;
    b = token_begin;
    bl = token_begin_line;
    bc = token_begin_column;
    wl = word_length;
    acc = number_accumulator;
    ov = number_overflow;
    for (int i = 0; i < MK; i++) wb[i] = word_buffer[i];
    c = char_in;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    prod = {4'd0, acc} * 67'd10 + 67'(c - "0");
    fall = 1'b0;
    ln_len = '0;
    kh = '0;
    t = '0;
    n = 3'd0;
    wb_we = 1'b0;
    wb_idx = '0;
    wb_dat = u;

    if (has_byte) begin
      unique case (m)
        MODE_ERROR: begin
        end
        MODE_IDLE: fall = 1'b1;
        MODE_MINUS: begin
          if (c == "-") begin
            p = inc_off(p); cl = inc_pos(cl); m = MODE_LCOMMENT;
          end else begin
            t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_MINUS, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "*") begin
            p = inc_off(p); cl = inc_pos(cl); m = MODE_BLOCK;
          end else begin
            t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_SLASH, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_LCOMMENT, MODE_BLOCK, MODE_BLOCK_STAR, MODE_STR, MODE_QID: begin
          p = inc_off(p);
          if (c == 8'h0A) begin
            ln = inc_pos(ln); cl = PB'(1);
          end else begin
            cl = inc_pos(cl);
          end
          if (m == MODE_LCOMMENT) begin
            if (c == 8'h0A) m = MODE_IDLE;
          end else if (m == MODE_BLOCK) begin
            if (c == "*") m = MODE_BLOCK_STAR;
          end else if (m == MODE_BLOCK_STAR) begin
            if (c == "/") m = MODE_IDLE;
            else if (c != "*") m = MODE_BLOCK;
          end else if (m == MODE_STR) begin
            if (c == "'") m = MODE_STR_QUOTE;
          end else begin
            if (c == "\"") begin
              t[n[1:0]] = mk_tok(KIND_IDENT, SUB_NONE, span(p, b), '0, b, bl, bc);
              n = n + 3'd1; m = MODE_IDLE;
            end
          end
        end
        MODE_WORD: begin
          if (is_word(c)) begin
            if (wl < WLW'(MK)) begin
              wb[wl[IW-1:0]] = u; wb_we = 1'b1; wb_idx = wl[IW-1:0]; wl = wl + 1'b1;
            end else begin
              wl = WLW'(MK + 1);
            end
            p = inc_off(p); cl = inc_pos(cl);
          end else begin
            kh = kw_match(wb, wl);
            if (kh.hit) t[n[1:0]] = mk_tok(KIND_KEYWORD, kh.idx, span(p, b), '0, b, bl, bc);
            else t[n[1:0]] = mk_tok(KIND_IDENT, SUB_NONE, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            if (!ov) begin
              if (prod > 67'(I63_MAX)) ov = 1'b1;
              else acc = prod[62:0];
            end
            p = inc_off(p); cl = inc_pos(cl);
          end else if (c == ".") begin
            p = inc_off(p); cl = inc_pos(cl); m = MODE_INT_DOT;
          end else if (ov) begin
            t[n[1:0]] = mk_tok(KIND_ERROR, ERR_OVERFLOW, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_ERROR;
          end else begin
            t[n[1:0]] = mk_tok(KIND_INT, SUB_NONE, span(p, b), acc, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          if (is_digit(c)) begin
            p = inc_off(p); cl = inc_pos(cl); m = MODE_FLOAT;
          end else begin
            ln_len = span(p, b);
            ln_len = (ln_len >= OB'(1)) ? ln_len - 1'b1 : '0;
            if (ov) begin
              t[n[1:0]] = mk_tok(KIND_ERROR, ERR_OVERFLOW, ln_len, '0, b, bl, bc);
              n = n + 3'd1; m = MODE_ERROR;
            end else begin
              t[n[1:0]] = mk_tok(KIND_INT, SUB_NONE, ln_len, acc, b, bl, bc);
              n = n + 3'd1;
              b = (p != '0) ? p - 1'b1 : '0;
              bl = ln;
              bc = (cl > PB'(1)) ? cl - 1'b1 : PB'(1);
              t[n[1:0]] = mk_tok(KIND_DELIM, DL_DOT, OB'(1), '0, b, bl, bc);
              n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
            end
          end
        end
        MODE_FLOAT: begin
          if (is_digit(c)) begin
            p = inc_off(p); cl = inc_pos(cl);
          end else begin
            t[n[1:0]] = mk_tok(KIND_FLOAT, SUB_NONE, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_STR_QUOTE: begin
          if (c == "'") begin
            p = inc_off(p); cl = inc_pos(cl); m = MODE_STR;
          end else begin
            t[n[1:0]] = mk_tok(KIND_STRING, SUB_NONE, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_LT: begin
          if (c == "=" || c == ">") begin
            p = inc_off(p); cl = inc_pos(cl);
            t[n[1:0]] = mk_tok(KIND_OPERATOR, (c == "=") ? OP_LE : OP_NE, span(p, b), '0,
                               b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE;
          end else begin
            t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_LT, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_GT: begin
          if (c == "=") begin
            p = inc_off(p); cl = inc_pos(cl);
            t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_GE, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE;
          end else begin
            t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_GT, span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE; fall = 1'b1;
          end
        end
        MODE_BANG, MODE_PIPE: begin
          if ((m == MODE_BANG && c == "=") || (m == MODE_PIPE && c == "|")) begin
            p = inc_off(p); cl = inc_pos(cl);
            t[n[1:0]] = mk_tok(KIND_OPERATOR, (m == MODE_BANG) ? OP_NE : OP_CONCAT,
                               span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_IDLE;
          end else begin
            t[n[1:0]] = mk_tok(KIND_ERROR, (m == MODE_BANG) ? ERR_BANG : ERR_PIPE,
                               span(p, b), '0, b, bl, bc);
            n = n + 3'd1; m = MODE_ERROR;
          end
        end
        default: m = MODE_IDLE;
      endcase

      if (fall) begin
        if (is_blank(c)) begin
          p = inc_off(p);
          if (c == 8'h0A) begin
            ln = inc_pos(ln); cl = PB'(1);
          end else begin
            cl = inc_pos(cl);
          end
        end else begin
          b = p; bl = ln; bc = cl;
          p = inc_off(p); cl = inc_pos(cl);
          if (is_alpha(c) || c == "_") begin
            wb[0] = u; wb_we = 1'b1; wb_idx = '0; wl = WLW'(1); m = MODE_WORD;
          end else if (is_digit(c)) begin
            acc = 63'(c - "0"); ov = 1'b0; m = MODE_INT;
          end else begin
            priority case (c)
              "'":  m = MODE_STR;
              "\"": m = MODE_QID;
              "-":  m = MODE_MINUS;
              "/":  m = MODE_SLASH;
              "<":  m = MODE_LT;
              ">":  m = MODE_GT;
              "!":  m = MODE_BANG;
              "|":  m = MODE_PIPE;
              "(", ")", ",", ";", ".", "*", "+", "%", "=": begin
                priority case (c)
                  "(": t[n[1:0]] = mk_tok(KIND_DELIM, DL_LPAREN, span(p, b), '0, b, bl, bc);
                  ")": t[n[1:0]] = mk_tok(KIND_DELIM, DL_RPAREN, span(p, b), '0, b, bl, bc);
                  ",": t[n[1:0]] = mk_tok(KIND_DELIM, DL_COMMA, span(p, b), '0, b, bl, bc);
                  ";": t[n[1:0]] = mk_tok(KIND_DELIM, DL_SEMI, span(p, b), '0, b, bl, bc);
                  ".": t[n[1:0]] = mk_tok(KIND_DELIM, DL_DOT, span(p, b), '0, b, bl, bc);
                  "*": t[n[1:0]] = mk_tok(KIND_DELIM, DL_STAR, span(p, b), '0, b, bl, bc);
                  "+": t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_PLUS, span(p, b), '0, b, bl, bc);
                  "%": t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_PERCENT, span(p, b), '0,
                                          b, bl, bc);
                  default: t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_EQ, span(p, b), '0,
                                              b, bl, bc);
                endcase
                n = n + 3'd1;
              end
              default: begin
                t[n[1:0]] = mk_tok(KIND_ERROR, ERR_BYTE, span(p, b), '0, b, bl, bc);
                n = n + 3'd1; m = MODE_ERROR;
              end
            endcase
          end
        end
      end
    end

    if (end_of_source) begin
      priority case (m)
        MODE_MINUS: begin
          t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_MINUS, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_SLASH: begin
          t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_SLASH, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_WORD: begin
          kh = kw_match(wb, wl);
          if (kh.hit) t[n[1:0]] = mk_tok(KIND_KEYWORD, kh.idx, span(p, b), '0, b, bl, bc);
          else t[n[1:0]] = mk_tok(KIND_IDENT, SUB_NONE, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_INT: begin
          if (ov) begin
            t[n[1:0]] = mk_tok(KIND_ERROR, ERR_OVERFLOW, span(p, b), '0, b, bl, bc);
            m = MODE_ERROR;
          end else begin
            t[n[1:0]] = mk_tok(KIND_INT, SUB_NONE, span(p, b), acc, b, bl, bc);
          end
          n = n + 3'd1;
        end
        MODE_INT_DOT: begin
          ln_len = span(p, b);
          ln_len = (ln_len >= OB'(1)) ? ln_len - 1'b1 : '0;
          if (ov) begin
            t[n[1:0]] = mk_tok(KIND_ERROR, ERR_OVERFLOW, ln_len, '0, b, bl, bc);
            n = n + 3'd1; m = MODE_ERROR;
          end else begin
            t[n[1:0]] = mk_tok(KIND_INT, SUB_NONE, ln_len, acc, b, bl, bc);
            n = n + 3'd1;
            b = (p != '0) ? p - 1'b1 : '0;
            bl = ln;
            bc = (cl > PB'(1)) ? cl - 1'b1 : PB'(1);
            t[n[1:0]] = mk_tok(KIND_DELIM, DL_DOT, OB'(1), '0, b, bl, bc);
            n = n + 3'd1;
          end
        end
        MODE_FLOAT: begin
          t[n[1:0]] = mk_tok(KIND_FLOAT, SUB_NONE, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_STR: begin
          t[n[1:0]] = mk_tok(KIND_ERROR, ERR_STRING, span(p, b), '0, b, bl, bc);
          n = n + 3'd1; m = MODE_ERROR;
        end
        MODE_STR_QUOTE: begin
          t[n[1:0]] = mk_tok(KIND_STRING, SUB_NONE, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_QID: begin
          t[n[1:0]] = mk_tok(KIND_ERROR, ERR_QIDENT, span(p, b), '0, b, bl, bc);
          n = n + 3'd1; m = MODE_ERROR;
        end
        MODE_LT: begin
          t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_LT, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_GT: begin
          t[n[1:0]] = mk_tok(KIND_OPERATOR, OP_GT, span(p, b), '0, b, bl, bc);
          n = n + 3'd1;
        end
        MODE_BANG: begin
          t[n[1:0]] = mk_tok(KIND_ERROR, ERR_BANG, span(p, b), '0, b, bl, bc);
          n = n + 3'd1; m = MODE_ERROR;
        end
        MODE_PIPE: begin
          t[n[1:0]] = mk_tok(KIND_ERROR, ERR_PIPE, span(p, b), '0, b, bl, bc);
          n = n + 3'd1; m = MODE_ERROR;
        end
        default: begin
        end
      endcase
      if (m != MODE_ERROR) begin
        t[n[1:0]] = mk_tok(KIND_END, SUB_NONE, '0, '0, p, ln, cl);
        n = n + 3'd1;
      end
      m = MODE_IDLE;
      p = '0;
      ln = PB'(1);
      cl = PB'(1);
      b = '0;
      bl = PB'(1);
      bc = PB'(1);
      wl = '0;
      acc = '0;
      ov = 1'b0;
    end

    for (int i = 0; i < RES_MAX; i++) t[i].last = (n == 3'(i + 1));

    scan_mode_next = m;
    byte_position_next = p;
    current_line_next = ln;
    current_column_next = cl;
    token_begin_next = b;
    token_begin_line_next = bl;
    token_begin_column_next = bc;
    word_length_next = wl;
    number_accumulator_next = acc;
    number_overflow_next = ov;
    toks = t;
    tok_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      byte_position <= '0;
      current_line <= PB'(1);
      current_column <= PB'(1);
      token_begin <= '0;
      token_begin_line <= PB'(1);
      token_begin_column <= PB'(1);
      word_length <= '0;
      number_accumulator <= '0;
      number_overflow <= 1'b0;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
      byte_position <= byte_position_next;
      current_line <= current_line_next;
      current_column <= current_column_next;
      token_begin <= token_begin_next;
      token_begin_line <= token_begin_line_next;
      token_begin_column <= token_begin_column_next;
      word_length <= word_length_next;
      number_accumulator <= number_accumulator_next;
      number_overflow <= number_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wb_we) word_buffer[wb_idx] <= wb_dat;
  end

endmodule

// File: rtl/core/sqlts_out_queue.sv
// Result register bank that holds the tokens of one item and hands them out one at a time.
module sqlts_out_queue
  import sqlts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tok_t [RES_MAX-1:0] toks,
  input  logic [2:0]         tok_count,
  input  logic               out_ready,
  output logic               out_valid,
  output tok_t               out_tok,
  output logic               can_load
);

  tok_t [RES_MAX-1:0] slots;
  logic [2:0]         count;
  logic [1:0]         rd;

  assign out_valid = (count != 3'd0);
  assign out_tok = slots[rd];
  assign can_load = (count == 3'd0) || (count == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      rd <= 2'd0;
    end else if (load) begin
      count <= tok_count;
      rd <= 2'd0;
    end else if (out_valid && out_ready) begin
      count <= count - 3'd1;
      rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slots <= toks;
  end

endmodule

// File: dv/tb_sql_token_scanner.sv
// Self-checking testbench for the streaming SQL token scanner.
`timescale 1ns / 1ps

module tb_sql_token_scanner;
  import sqlts_pkg::*;

  typedef struct {
    logic       has;
    logic [7:0] ch;
    logic       eos;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        has_byte = 1'b0;
  logic [7:0]  char_in = 8'h00;
  logic        end_of_source = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  token_kind;
  logic [5:0]  token_subtype;
  logic [19:0] start_offset;
  logic [19:0] token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [62:0] int_value;
  logic        last_of_run;

  sql_token_scanner dut (.*);

  src_item_t pending_src[$];
  tok_t      expected_toks[$];
  tok_t      item_toks[$];
  int        mismatches = 0;
  int        accepted_items = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        quiet = 1'b0;
  bit        hold_output = 1'b0;
  bit        sending_done = 1'b0;

  mode_t       mode;
  logic [19:0] pos;
  logic [15:0] line_no, col_no;
  logic [19:0] tok_pos;
  logic [15:0] tok_line, tok_col;
  logic [7:0]  word_chars[MAX_KEYWORD_CHARS_DEF];
  int          word_len;
  logic [63:0] acc;
  bit          acc_ovf;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void scan_reset();
    mode = MODE_IDLE;
    pos = '0;
    line_no = 16'd1;
    col_no = 16'd1;
    tok_pos = '0;
    tok_line = 16'd1;
    tok_col = 16'd1;
    word_len = 0;
    acc = '0;
    acc_ovf = 1'b0;
  endfunction

  function automatic void emit_tok(logic [3:0] kind, logic [5:0] sub, logic [63:0] len,
                                   logic [63:0] val);
    tok_t t;
    if (item_toks.size() >= RES_MAX) return;
    t.kind = kind;
    t.subtype = sub;
    t.offset = tok_pos;
    t.length = (len > 64'(F20_MAX)) ? F20_MAX : len[19:0];
    t.line = tok_line;
    t.column = tok_col;
    t.value = val[62:0];
    t.last = 1'b0;
    item_toks = {item_toks, t};
  endfunction

  function automatic logic [63:0] tok_span();
    return (pos >= tok_pos) ? 64'(pos - tok_pos) : 64'd0;
  endfunction

  function automatic void emit_span(logic [3:0] kind, logic [5:0] sub);
    emit_tok(kind, sub, tok_span(), 64'd0);
  endfunction

  function automatic void raise_error(logic [5:0] code);
    emit_span(KIND_ERROR, code);
    mode = MODE_ERROR;
  endfunction

  function automatic void advance(logic [7:0] c);
    if (pos < F20_MAX) pos++;
    if (c == 8'h0A) begin
      if (line_no < F16_MAX) line_no++;
      col_no = 16'd1;
    end else if (col_no < F16_MAX) begin
      col_no++;
    end
  endfunction

  function automatic void mark_start();
    tok_pos = pos;
    tok_line = line_no;
    tok_col = col_no;
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void word_add(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (word_len < MAX_KEYWORD_CHARS_DEF) begin
      word_chars[word_len] = u;
      word_len++;
    end else begin
      word_len = MAX_KEYWORD_CHARS_DEF + 1;
    end
  endfunction

  function automatic void word_done();
    int n;
    bit same;
    logic [7:0] b;
    if (word_len <= MAX_KEYWORD_CHARS_DEF) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        n = 0;
        for (int i = 0; i < KW_CHARS; i++)
          if (KW_TEXT[k][8*KW_CHARS-1-8*i -: 8] != " ") n = i + 1;
        same = (n == word_len);
        for (int i = 0; i < n && same; i++) begin
          b = KW_TEXT[k][8*KW_CHARS-1-8*i -: 8];
          if (b != word_chars[i]) same = 1'b0;
        end
        if (same) begin
          emit_span(KIND_KEYWORD, 6'(k));
          return;
        end
      end
    end
    emit_span(KIND_IDENT, SUB_NONE);
  endfunction

  function automatic void digit_add(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - "0");
    if (acc_ovf) return;
    if (acc > (64'(I63_MAX) - d) / 10) acc_ovf = 1'b1;
    else acc = acc * 10 + d;
  endfunction

  function automatic bit int_done(int back);
    logic [63:0] len;
    len = tok_span();
    len = (len >= 64'(back)) ? len - 64'(back) : 64'd0;
    if (acc_ovf) begin
      emit_tok(KIND_ERROR, ERR_OVERFLOW, len, 64'd0);
      mode = MODE_ERROR;
      return 1'b0;
    end
    emit_tok(KIND_INT, SUB_NONE, len, acc);
    return 1'b1;
  endfunction

  function automatic void dot_after_int();
    tok_pos = (pos > 0) ? pos - 20'd1 : 20'd0;
    tok_line = line_no;
    tok_col = (col_no > 1) ? col_no - 16'd1 : 16'd1;
    emit_tok(KIND_DELIM, DL_DOT, 64'd1, 64'd0);
  endfunction

  function automatic void start_tok(logic [7:0] c);
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      advance(c);
      return;
    end
    mark_start();
    if (alpha_c(c) || c == "_") begin
      word_len = 0;
      word_add(c);
      advance(c);
      mode = MODE_WORD;
      return;
    end
    if (digit_c(c)) begin
      acc = '0;
      acc_ovf = 1'b0;
      digit_add(c);
      advance(c);
      mode = MODE_INT;
      return;
    end
    advance(c);
    case (c)
      "'": mode = MODE_STR;
      "\"": mode = MODE_QID;
      "(": emit_span(KIND_DELIM, DL_LPAREN);
      ")": emit_span(KIND_DELIM, DL_RPAREN);
      ",": emit_span(KIND_DELIM, DL_COMMA);
      ";": emit_span(KIND_DELIM, DL_SEMI);
      ".": emit_span(KIND_DELIM, DL_DOT);
      "*": emit_span(KIND_DELIM, DL_STAR);
      "+": emit_span(KIND_OPERATOR, OP_PLUS);
      "%": emit_span(KIND_OPERATOR, OP_PERCENT);
      "=": emit_span(KIND_OPERATOR, OP_EQ);
      "-": mode = MODE_MINUS;
      "/": mode = MODE_SLASH;
      "<": mode = MODE_LT;
      ">": mode = MODE_GT;
      "!": mode = MODE_BANG;
      "|": mode = MODE_PIPE;
      default: raise_error(ERR_BYTE);
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    bit held;
    for (int p = 0; p < 3; p++) begin
      held = 1'b1;
      case (mode)
        MODE_ERROR: ;
        MODE_IDLE: start_tok(c);
        MODE_MINUS:
          if (c == "-") begin advance(c); mode = MODE_LCOMMENT; end
          else begin emit_span(KIND_OPERATOR, OP_MINUS); held = 1'b0; end
        MODE_SLASH:
          if (c == "*") begin advance(c); mode = MODE_BLOCK; end
          else begin emit_span(KIND_OPERATOR, OP_SLASH); held = 1'b0; end
        MODE_LCOMMENT: begin
          advance(c);
          if (c == 8'h0A) mode = MODE_IDLE;
        end
        MODE_BLOCK: begin
          advance(c);
          if (c == "*") mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          advance(c);
          if (c == "/") mode = MODE_IDLE;
          else if (c != "*") mode = MODE_BLOCK;
        end
        MODE_WORD:
          if (alpha_c(c) || digit_c(c) || c == "_") begin word_add(c); advance(c); end
          else begin word_done(); held = 1'b0; end
        MODE_INT:
          if (digit_c(c)) begin digit_add(c); advance(c); end
          else if (c == ".") begin advance(c); mode = MODE_INT_DOT; end
          else if (int_done(0)) held = 1'b0;
        MODE_INT_DOT:
          if (digit_c(c)) begin advance(c); mode = MODE_FLOAT; end
          else if (int_done(1)) begin dot_after_int(); held = 1'b0; end
        MODE_FLOAT:
          if (digit_c(c)) advance(c);
          else begin emit_span(KIND_FLOAT, SUB_NONE); held = 1'b0; end
        MODE_STR: begin
          advance(c);
          if (c == "'") mode = MODE_STR_QUOTE;
        end
        MODE_STR_QUOTE:
          if (c == "'") begin advance(c); mode = MODE_STR; end
          else begin emit_span(KIND_STRING, SUB_NONE); held = 1'b0; end
        MODE_QID: begin
          advance(c);
          if (c == "\"") begin emit_span(KIND_IDENT, SUB_NONE); mode = MODE_IDLE; end
        end
        MODE_LT:
          if (c == "=") begin advance(c); emit_span(KIND_OPERATOR, OP_LE); mode = MODE_IDLE; end
          else if (c == ">") begin
            advance(c); emit_span(KIND_OPERATOR, OP_NE); mode = MODE_IDLE;
          end else begin emit_span(KIND_OPERATOR, OP_LT); held = 1'b0; end
        MODE_GT:
          if (c == "=") begin advance(c); emit_span(KIND_OPERATOR, OP_GE); mode = MODE_IDLE; end
          else begin emit_span(KIND_OPERATOR, OP_GT); held = 1'b0; end
        MODE_BANG:
          if (c == "=") begin advance(c); emit_span(KIND_OPERATOR, OP_NE); mode = MODE_IDLE; end
          else raise_error(ERR_BANG);
        MODE_PIPE:
          if (c == "|") begin
            advance(c); emit_span(KIND_OPERATOR, OP_CONCAT); mode = MODE_IDLE;
          end else raise_error(ERR_PIPE);
        default: held = 1'b0;
      endcase
      if (held) return;
      mode = MODE_IDLE;
    end
  endfunction

  function automatic void scan_flush();
    case (mode)
      MODE_MINUS: emit_span(KIND_OPERATOR, OP_MINUS);
      MODE_SLASH: emit_span(KIND_OPERATOR, OP_SLASH);
      MODE_WORD: word_done();
      MODE_INT: void'(int_done(0));
      MODE_INT_DOT: if (int_done(1)) dot_after_int();
      MODE_FLOAT: emit_span(KIND_FLOAT, SUB_NONE);
      MODE_STR: raise_error(ERR_STRING);
      MODE_STR_QUOTE: emit_span(KIND_STRING, SUB_NONE);
      MODE_QID: raise_error(ERR_QIDENT);
      MODE_LT: emit_span(KIND_OPERATOR, OP_LT);
      MODE_GT: emit_span(KIND_OPERATOR, OP_GT);
      MODE_BANG: raise_error(ERR_BANG);
      MODE_PIPE: raise_error(ERR_PIPE);
      default: ;
    endcase
    if (mode != MODE_ERROR) begin
      mark_start();
      emit_tok(KIND_END, SUB_NONE, 64'd0, 64'd0);
    end
  endfunction

  function automatic void predict_tokens(src_item_t it);
    item_toks.delete();
    if (it.has) scan_byte(it.ch);
    if (it.eos) begin
      scan_flush();
      scan_reset();
    end
    if (item_toks.size() > 0) item_toks[item_toks.size()-1].last = 1'b1;
    foreach (item_toks[i]) expected_toks = {expected_toks, item_toks[i]};
  endfunction

  function automatic void push_byte(logic [7:0] c);
    src_item_t it;
    it.has = 1'b1;
    it.ch = c;
    it.eos = 1'b0;
    pending_src = {pending_src, it};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_ctrl(logic has, logic [7:0] c, logic eos);
    src_item_t it;
    it.has = has;
    it.ch = c;
    it.eos = eos;
    pending_src = {pending_src, it};
  endfunction

  function automatic void push_fragment();
    string ops[12] = '{"+", "-", "/", "%", "=", "<>", "!=", "<", "<=", ">", ">=", "||"};
    string dls = "(),;.*";
    string wch = "abcXYZ_09q";
    int r, n, k;
    logic [7:0] b;
    r = $urandom_range(0, 19);
    case (r)
      0, 1, 2, 3: begin
        k = $urandom_range(0, KW_COUNT - 1);
        for (int i = 0; i < KW_CHARS; i++) begin
          b = KW_TEXT[k][8*KW_CHARS-1-8*i -: 8];
          if (b != " ") push_byte($urandom_range(0, 1) ? (b | 8'h20) : b);
        end
      end
      4: begin
        push_byte($urandom_range(0, 1) ? "_" : 8'($urandom_range("a", "z")));
        n = $urandom_range(0, 11);
        repeat (n) push_byte(wch[$urandom_range(0, wch.len() - 1)]);
      end
      5: begin
        n = $urandom_range(0, 3) == 0 ? $urandom_range(18, 21) : $urandom_range(1, 5);
        repeat (n) push_byte(8'($urandom_range("0", "9")));
      end
      6: begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range("0", "9")));
        push_byte(".");
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range("0", "9")));
      end
      7: push_text($urandom_range(0, 1) ? "'ab''c'" : "'x y'");
      8: push_text("\"Col 1\"");
      9: push_text(ops[$urandom_range(0, 11)]);
      10: push_byte(dls[$urandom_range(0, 5)]);
      11: push_text("-- note *\n");
      12: push_text("/* a ** b */");
      13: push_byte($urandom_range(0, 1) ? 8'h0A : 8'h09);
      14: push_byte(8'($urandom_range(0, 255)));
      15: push_ctrl(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      16: push_ctrl(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      default: push_byte(" ");
    endcase
    if ($urandom_range(0, 2) != 0) push_byte($urandom_range(0, 3) == 0 ? 8'h0D : " ");
    if ($urandom_range(0, 11) == 0) push_ctrl(1'($urandom_range(0, 1)), " ", 1'b1);
  endfunction

  initial begin
    int directed;
    scan_reset();
    push_text("Select 9.5,'a''b'");
    push_ctrl(1'b1, ";", 1'b1);
    push_text("1.x");
    push_ctrl(1'b0, 8'h00, 1'b1);
    push_byte(8'hFF);
    push_byte("a");
    push_ctrl(1'b0, 8'h00, 1'b1);
    push_ctrl(1'b0, 8'hA5, 1'b0);
    push_text("/* c");
    push_ctrl(1'b1, 8'h00, 1'b1);
    push_ctrl(1'b0, 8'h00, 1'b1);
    directed = pending_src.size();
    while (pending_src.size() < directed + 160) push_fragment();
    push_ctrl(1'b0, 8'h00, 1'b1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    src_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        it.has = has_byte;
        it.ch = char_in;
        it.eos = end_of_source;
        predict_tokens(it);
        accepted_items++;
      end
      if (pending_src.size() < 40) quiet = 1'b1;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (pending_src.size() > 0) begin
        it = pending_src.pop_front();
        has_byte <= it.has;
        char_in <= it.ch;
        end_of_source <= it.eos;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        sending_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tok_t got, exp_tok;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = token_kind;
        got.subtype = token_subtype;
        got.offset = start_offset;
        got.length = token_length;
        got.line = start_line;
        got.column = start_column;
        got.value = int_value;
        got.last = last_of_run;
        if (expected_toks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %h", got);
        end else begin
          exp_tok = expected_toks.pop_front();
          if (got !== exp_tok) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %h, got %h", exp_tok, got);
          end
        end
      end
      if (hold_output) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (accepted_items >= 40);
    hold_output = 1'b1;
    repeat (300) @(posedge clk);
    hold_output = 1'b0;
  end

  initial begin
    wait (!rst);
    while (!sending_done || expected_toks.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_toks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/sqlts_pkg.sv
rtl/core/sqlts_lexer.sv
rtl/core/sqlts_out_queue.sv
rtl/core/sql_token_scanner.sv
dv/tb_sql_token_scanner.sv
